// ===== design/ssbiu_pkg.sv =====
// package for the scanline split bank and irq unit
// register offsets, control bits, line constants and beat payload structs
// no dependencies
`timescale 1ns / 1ps

package ssbiu_pkg;

  localparam int PLAN_DEPTH_DEFAULT = 16;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } req_kind_t;

  typedef enum logic [7:0] {
    OFF_CONTROL        = 8'h01,
    OFF_CNT_LO         = 8'h02,
    OFF_CNT_HI         = 8'h06,
    OFF_STATUS         = 8'h09,
    OFF_PUSH_LINES     = 8'h0A,
    OFF_PLAN_CLEAR     = 8'h12,
    OFF_PUSH_BANKS     = 8'h1A,
    OFF_COMMIT         = 8'h22,
    OFF_PLAN_REWIND    = 8'h2A,
    OFF_STATUS_RESTORE = 8'h98,
    OFF_IRQ_ACK        = 8'hB0
  } reg_off_t;

  localparam int CTRL_SPLIT  = 6;
  localparam int CTRL_IRQ_EN = 2;

  localparam logic [7:0] STATUS_IRQ_MASK = 8'h02;

  localparam logic signed [9:0] LINE_PRE        = -10'sd1;
  localparam logic signed [9:0] LINE_IRQ        = 10'sd239;
  localparam logic signed [9:0] LINE_LAST_COUNT = 10'sd241;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        reg_offset;
    logic [7:0]        write_data;
    logic signed [9:0] line_number;
    logic              is_rendering;
  } ssbiu_req_t;

  typedef struct packed {
    logic       irq_line;
    logic       bank_update;
    logic [3:0] chr_bank_low;
    logic [3:0] chr_bank_high;
    logic [1:0] mirror_mode;
    logic [7:0] status_value;
  } ssbiu_res_t;

endpackage

// ===== design/ssbiu_req_if.sv =====
// request channel: register writes and scanline ticks
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps

interface ssbiu_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [7:0]        reg_offset;
  logic [7:0]        write_data;
  logic signed [9:0] line_number;
  logic              is_rendering;

  modport source (
    output valid, req_type, reg_offset, write_data, line_number, is_rendering,
    input  ready
  );

  modport sink (
    input  valid, req_type, reg_offset, write_data, line_number, is_rendering,
    output ready
  );
endinterface

// ===== design/ssbiu_res_if.sv =====
// result channel: irq, chr bank pair, mirroring and status byte
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps

interface ssbiu_res_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic       bank_update;
  logic [3:0] chr_bank_low;
  logic [3:0] chr_bank_high;
  logic [1:0] mirror_mode;
  logic [7:0] status_value;

  modport source (
    output valid, irq_line, bank_update, chr_bank_low, chr_bank_high, mirror_mode,
           status_value,
    input  ready
  );

  modport sink (
    input  valid, irq_line, bank_update, chr_bank_low, chr_bank_high, mirror_mode,
           status_value,
    output ready
  );
endinterface

// ===== design/ssbiu_out_buf.sv =====
// two-entry result buffer that drives the result channel
// depends on ssbiu_pkg and ssbiu_res_if
`timescale 1ns / 1ps

module ssbiu_out_buf import ssbiu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  ssbiu_res_t  push_data,
  ssbiu_res_if.source res
);

  localparam logic [1:0] BUF_DEPTH = 2'd2;

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  ssbiu_res_t ent [2];
  ssbiu_res_t head;

  assign push_ready = (cnt != BUF_DEPTH);
  assign push       = push_valid && push_ready;
  assign pop        = res.valid && res.ready;
  assign cnt_next   = cnt + 2'(push) - 2'(pop);

  assign head              = ent[rd_ptr];
  assign res.valid         = (cnt != 2'd0);
  assign res.irq_line      = head.irq_line;
  assign res.bank_update   = head.bank_update;
  assign res.chr_bank_low  = head.chr_bank_low;
  assign res.chr_bank_high = head.chr_bank_high;
  assign res.mirror_mode   = head.mirror_mode;
  assign res.status_value  = head.status_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= BUF_DEPTH)
    else $error("result buffer over capacity");

  a_cnt_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 2'd1)
    else $error("result buffer count lost a push");

  a_cnt_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - 2'd1)
    else $error("result buffer count lost a pop");

endmodule

// ===== design/scanline_split_bank_irq_unit_top.sv =====
// top level of the scanline split bank and irq unit
// depends on ssbiu_pkg, ssbiu_req_if, ssbiu_res_if and ssbiu_out_buf
`timescale 1ns / 1ps

// The unit takes one beat per clock, either a register write in the FF00 page or a
// scanline tick, and returns exactly one result beat for each, in order. A beat is
// captured in an input register, processed against the unit state, and its result
// sits in a two-entry output buffer; the sustained rate is one beat per cycle for as
// long as the result side keeps taking beats. The active plan and the staged queues
// share one memory per queue kind, split into two halves that swap roles on a
// commit, so a commit is a swap of halves and there is no clearing pass after reset.
// Plan entries are prefetched into registers at the plan position and at the plan
// start, so a tick reads its plan entry from registers and not from the memory.

module scanline_split_bank_irq_unit_top import ssbiu_pkg::*; #(
  parameter int PLAN_DEPTH = PLAN_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  ssbiu_req_if.sink   req,
  ssbiu_res_if.source res
);

  localparam int CW        = $clog2(PLAN_DEPTH + 1);
  localparam int IW        = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;
  localparam int MEM_DEPTH = 2 * PLAN_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(PLAN_DEPTH);

  logic       in_valid;
  ssbiu_req_t in_q;
  logic       adv;
  logic       buf_ready;

  logic [7:0]    control_byte, control_byte_next;
  logic [7:0]    line_counter, line_counter_next;
  logic [CW-1:0] plan_position, plan_position_next;
  logic [CW-1:0] plan_lines_used, plan_lines_used_next;
  logic [CW-1:0] plan_banks_used, plan_banks_used_next;
  logic [CW-1:0] staged_lines_used, staged_lines_used_next;
  logic [CW-1:0] staged_banks_used, staged_banks_used_next;
  logic [7:0]    status_byte, status_byte_next;
  logic [7:0]    saved_status, saved_status_next;
  logic          irq_pending, irq_pending_next;
  logic          sel, sel_next;

  logic [7:0] lines_mem [MEM_DEPTH];
  logic [7:0] banks_mem [MEM_DEPTH];
  logic [7:0] lines_at_pos, lines_at_zero;
  logic [7:0] banks_at_pos, banks_at_zero;

  logic          wr_lines, wr_banks;
  logic [AW-1:0] wr_addr_lines, wr_addr_banks;
  logic          raise;
  logic          upd;
  logic [3:0]    lo, hi;
  logic          irq_en;
  ssbiu_res_t    res_d;

  function automatic logic [AW-1:0] mem_addr(input logic half, input logic [CW-1:0] p);
    mem_addr = AW'(p[IW-1:0]) + (half ? AW'(PLAN_DEPTH) : AW'(0));
  endfunction

  // input stage
  assign adv       = in_valid && buf_ready;
  assign req.ready = !in_valid || buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q <= {req.req_type, req.reg_offset, req.write_data, req.line_number,
               req.is_rendering};
    end
  end

  assign irq_en        = control_byte[CTRL_IRQ_EN];
  assign wr_addr_lines = mem_addr(!sel, staged_lines_used);
  assign wr_addr_banks = mem_addr(!sel, staged_banks_used);

  always_comb begin
    logic [7:0]    lc_t;
    logic [CW-1:0] pos_t;
    logic          use_zero;
    logic [7:0]    bank_t;

    control_byte_next      = control_byte;
    line_counter_next      = line_counter;
    plan_position_next     = plan_position;
    plan_lines_used_next   = plan_lines_used;
    plan_banks_used_next   = plan_banks_used;
    staged_lines_used_next = staged_lines_used;
    staged_banks_used_next = staged_banks_used;
    status_byte_next       = status_byte;
    saved_status_next      = saved_status;
    irq_pending_next       = irq_pending;
    sel_next               = sel;
    wr_lines               = 1'b0;
    wr_banks               = 1'b0;
    raise                  = 1'b0;
    upd                    = 1'b0;
    lo                     = 4'd0;
    hi                     = 4'd0;
    lc_t                   = line_counter;
    pos_t                  = plan_position;
    use_zero               = 1'b0;
    bank_t                 = 8'd0;

    if (adv) begin
      if (in_q.req_type == REQ_WRITE) begin
        case (in_q.reg_offset)
          OFF_CONTROL: begin
            control_byte_next = in_q.write_data;
            if (!in_q.write_data[CTRL_IRQ_EN]) irq_pending_next = 1'b0;
          end
          OFF_CNT_LO: line_counter_next = {line_counter[7:4], in_q.write_data[3:0]};
          OFF_CNT_HI: line_counter_next = {in_q.write_data[3:0], line_counter[3:0]};
          OFF_STATUS: status_byte_next = in_q.write_data;
          OFF_PUSH_LINES: begin
            if (staged_lines_used < DEPTH_C) begin
              wr_lines               = 1'b1;
              staged_lines_used_next = staged_lines_used + CW'(1);
            end
          end
          OFF_PUSH_BANKS: begin
            if (staged_banks_used < DEPTH_C) begin
              wr_banks               = 1'b1;
              staged_banks_used_next = staged_banks_used + CW'(1);
            end
          end
          OFF_PLAN_CLEAR: begin
            plan_lines_used_next = '0;
            plan_banks_used_next = '0;
            plan_position_next   = '0;
          end
          OFF_COMMIT: begin
            plan_lines_used_next   = staged_lines_used;
            plan_banks_used_next   = staged_banks_used;
            staged_lines_used_next = '0;
            staged_banks_used_next = '0;
            sel_next               = !sel;
          end
          OFF_PLAN_REWIND: plan_position_next = '0;
          OFF_STATUS_RESTORE: begin
            status_byte_next = saved_status;
            irq_pending_next = 1'b0;
          end
          OFF_IRQ_ACK: irq_pending_next = 1'b0;
          default: ;
        endcase
      end else if (control_byte[CTRL_SPLIT]) begin
        if (in_q.line_number == LINE_PRE) begin
          pos_t    = '0;
          lc_t     = 8'd0;
          use_zero = 1'b1;
        end else if (in_q.line_number < LINE_LAST_COUNT) begin
          lc_t = line_counter + 8'd1;
        end
        if (lc_t == 8'd0 && pos_t < plan_banks_used && pos_t < plan_lines_used) begin
          bank_t = use_zero ? banks_at_zero : banks_at_pos;
          upd    = 1'b1;
          lo     = bank_t[3:0];
          hi     = bank_t[7:4];
          lc_t   = use_zero ? lines_at_zero : lines_at_pos;
          pos_t  = pos_t + CW'(1);
        end
        line_counter_next  = lc_t;
        plan_position_next = pos_t;
        if (in_q.line_number == LINE_IRQ && irq_en) raise = 1'b1;
      end else if (in_q.is_rendering) begin
        lc_t              = line_counter + 8'd1;
        line_counter_next = lc_t;
        if (lc_t == 8'd0 && irq_en) raise = 1'b1;
      end

      if (raise) begin
        irq_pending_next  = 1'b1;
        saved_status_next = status_byte;
        status_byte_next  = status_byte | STATUS_IRQ_MASK;
      end
    end
  end

  always_comb begin
    res_d.irq_line      = irq_pending_next;
    res_d.bank_update   = upd;
    res_d.chr_bank_low  = lo;
    res_d.chr_bank_high = hi;
    res_d.mirror_mode   = control_byte_next[1:0];
    res_d.status_value  = status_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte      <= 8'd0;
      line_counter      <= 8'd0;
      plan_position     <= '0;
      plan_lines_used   <= '0;
      plan_banks_used   <= '0;
      staged_lines_used <= '0;
      staged_banks_used <= '0;
      status_byte       <= 8'd0;
      saved_status      <= 8'd0;
      irq_pending       <= 1'b0;
      sel               <= 1'b0;
    end else begin
      control_byte      <= control_byte_next;
      line_counter      <= line_counter_next;
      plan_position     <= plan_position_next;
      plan_lines_used   <= plan_lines_used_next;
      plan_banks_used   <= plan_banks_used_next;
      staged_lines_used <= staged_lines_used_next;
      staged_banks_used <= staged_banks_used_next;
      status_byte       <= status_byte_next;
      saved_status      <= saved_status_next;
      irq_pending       <= irq_pending_next;
      sel               <= sel_next;
    end
  end

  // staged half written, plan half prefetched at position and at start
  always_ff @(posedge clk) begin
    if (wr_lines) lines_mem[wr_addr_lines] <= in_q.write_data;
    lines_at_pos  <= lines_mem[mem_addr(sel_next, plan_position_next)];
    lines_at_zero <= lines_mem[mem_addr(sel_next, '0)];
  end

  always_ff @(posedge clk) begin
    if (wr_banks) banks_mem[wr_addr_banks] <= in_q.write_data;
    banks_at_pos  <= banks_mem[mem_addr(sel_next, plan_position_next)];
    banks_at_zero <= banks_mem[mem_addr(sel_next, '0)];
  end

  ssbiu_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (adv),
    .push_ready (buf_ready),
    .push_data  (res_d),
    .res        (res)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    staged_lines_used <= DEPTH_C && staged_banks_used <= DEPTH_C &&
    plan_lines_used <= DEPTH_C && plan_banks_used <= DEPTH_C)
    else $error("queue fill count beyond plan depth");

  a_pos_after_update: assert property (@(posedge clk) disable iff (rst)
    (adv && upd) |=> plan_position != '0 && plan_position <= plan_lines_used &&
    plan_position <= plan_banks_used)
    else $error("plan position out of range after bank update");

  a_commit_swap: assert property (@(posedge clk) disable iff (rst)
    (adv && in_q.req_type == REQ_WRITE && in_q.reg_offset == OFF_COMMIT) |=>
    sel != $past(sel) && staged_lines_used == '0 && staged_banks_used == '0)
    else $error("commit did not swap halves or empty staged queues");

  a_raise_sets_status: assert property (@(posedge clk) disable iff (rst)
    (adv && raise) |=> irq_pending && status_byte[1])
    else $error("irq raise did not mark pending and status");

  a_no_bank_normal: assert property (@(posedge clk) disable iff (rst)
    (adv && !control_byte[CTRL_SPLIT]) |-> !upd)
    else $error("bank update outside split mode");

endmodule
